@@ src/life_cell_automaton_step_unit_macros.svh @@
// Assertion macros for the Life generation step unit.
// Included by the top level; needs nothing else.
`ifndef LIFE_CELL_AUTOMATON_STEP_UNIT_MACROS_SVH
`define LIFE_CELL_AUTOMATON_STEP_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define LCAS_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the cycle after the antecedent.
`define LCAS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lcas_pkg.sv @@
// Shared types, constants and the B3/S23 rule for the Life step unit.
// No dependencies.
package lcas_pkg;

  localparam int CFG_W          = 10;
  localparam int CFG_IDX_W      = 1;
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int GRID_WIDTH_RST  = 480;
  localparam int GRID_HEIGHT_RST = 269;
  localparam int OUT_FIFO_DEPTH = 8;
  localparam int WIN_COL_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // one column of the window: bit 0 upper row, bit 1 middle, bit 2 lower
  typedef logic [WIN_COL_W-1:0] win_col_t;

  typedef struct packed {
    logic upper;
    logic middle;
  } line_pair_t;

  typedef struct packed {
    logic next_alive;
    logic row_end;
    logic frame_end;
  } result_t;

  // per-cell flags carried from acceptance into the window stage
  typedef struct packed {
    logic bot;
    logic col_zero;
    logic row_ge1;
    logic row_ge2;
    logic last_col;
    logic padding;
  } cell_flags_t;

  // bit (col*3 + row), centre is bit 4
  function automatic logic life_next(input logic [8:0] win);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) cnt = cnt + {3'b000, win[k]};
    end
    return (cnt == 4'd3) || ((cnt == 4'd2) && win[4]);
  endfunction

endpackage

@@ src/lcas_win_cell.sv @@
// One column cell of the 3x3 window chain.
// Uses lcas_pkg for the column type.
module lcas_win_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  logic              clear,
  input  lcas_pkg::win_col_t col_in,
  output lcas_pkg::win_col_t col_q,
  output lcas_pkg::win_col_t col_nxt
);

  lcas_pkg::win_col_t col_r;

  assign col_nxt = clear ? '0 : col_in;
  assign col_q   = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_nxt;
    end
  end

endmodule

@@ src/lcas_line_store.sv @@
// Paired line store: row two above and row just above, one entry per column.
// Uses lcas_pkg for the entry type. Read data is registered.
module lcas_line_store #(
  parameter int DEPTH  = lcas_pkg::MAX_WIDTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic [ADDR_W-1:0]    rd_addr,
  output lcas_pkg::line_pair_t rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  lcas_pkg::line_pair_t wr_data
);

  lcas_pkg::line_pair_t mem [DEPTH];
  lcas_pkg::line_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/lcas_out_fifo.sv @@
// Result queue: takes up to two results a cycle, hands out one.
// Uses lcas_pkg for the result type and depth.
module lcas_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_a,
  input  lcas_pkg::result_t data_a,
  input  logic              push_b,
  input  lcas_pkg::result_t data_b,
  input  logic              pop,
  output logic              not_empty,
  output lcas_pkg::result_t head,
  output logic [$clog2(lcas_pkg::OUT_FIFO_DEPTH+1)-1:0] level
);

  localparam int DEPTH = lcas_pkg::OUT_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH+1);

  lcas_pkg::result_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] n_push;
  logic             do_pop;

  // push_b is only raised together with push_a
  assign n_push = push_a ? (push_b ? LVL_W'(2) : LVL_W'(1)) : '0;
  assign do_pop = pop && (level_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    level_nxt  = level_r + n_push - (do_pop ? LVL_W'(1) : LVL_W'(0));
  end

  always_ff @(posedge clk) begin
    if (push_a) entry_r[wr_ptr_r] <= data_a;
    if (push_a && push_b) entry_r[wr_ptr_r + PTR_W'(1)] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  assign not_empty = (level_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign level     = level_r;

endmodule

@@ src/life_cell_automaton_step_unit.sv @@
// Life generation step unit (birth on 3, survival on 2 or 3) on a raster stream.
// Uses lcas_pkg, lcas_win_cell, lcas_line_store, lcas_out_fifo and the macros header.
//
// Cells of the current generation enter one per cycle, when in_ready is high, in
// raster order: grid_height rows of grid_width cells, then one padding row of
// grid_width cells whose values are ignored. Each frame returns grid_width *
// grid_height next-generation cells in raster order, each flagged with row_end and
// frame_end; a cell leaves one row and one column after it entered, the last cell
// of each row arriving together with the one before it. An accepted cell is read
// against the paired line store (one registered read port) in the next cycle,
// shifts a chain of three window column cells and lands in an 8-entry result
// queue. The unit takes one cell every cycle while the queue keeps room for two
// results of the cell in flight and two of the next one; with out_ready held high
// the queue never fills. After reset a clearing pass zeroes the line store, one
// column a cycle across all MAX_WIDTH columns, with in_ready low; configuration
// writes are taken at any time. Width below 2 acts as 2, above MAX_WIDTH as
// MAX_WIDTH; height 0 acts as 1, above MAX_HEIGHT as MAX_HEIGHT.
`include "life_cell_automaton_step_unit_macros.svh"

module life_cell_automaton_step_unit #(
  parameter int MAX_WIDTH  = lcas_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lcas_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input cell stream
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cell_alive,
  // result stream
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_next_alive,
  output logic                           out_row_end,
  output logic                           out_frame_end,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcas_pkg::CFG_W-1:0]     cfg_wr_data
);

  localparam int CFG_W  = lcas_pkg::CFG_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
  localparam int BIG_W  = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                          $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
  // compare width: holds the register value and both limits
  localparam int CMP_W  = ((BIG_W > CFG_W) ? BIG_W : CFG_W) + 1;
  localparam int DEPTH  = lcas_pkg::OUT_FIFO_DEPTH;
  localparam int LVL_W  = $clog2(DEPTH + 1);

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] grid_width_r, grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W'(lcas_pkg::GRID_WIDTH_RST);
      grid_height_r <= CFG_W'(lcas_pkg::GRID_HEIGHT_RST);
    end else if (cfg_wr_en) begin
      case (lcas_pkg::cfg_reg_e'(cfg_index))
        lcas_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_wr_data;
        lcas_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CMP_W-1:0] gw_ext, gh_ext, eff_w, eff_h;

  always_comb begin
    gw_ext = CMP_W'(grid_width_r);
    gh_ext = CMP_W'(grid_height_r);
    if (gw_ext < CMP_W'(2))              eff_w = CMP_W'(2);
    else if (gw_ext > CMP_W'(MAX_WIDTH)) eff_w = CMP_W'(MAX_WIDTH);
    else                                 eff_w = gw_ext;
    if (gh_ext < CMP_W'(1))               eff_h = CMP_W'(1);
    else if (gh_ext > CMP_W'(MAX_HEIGHT)) eff_h = CMP_W'(MAX_HEIGHT);
    else                                  eff_h = gh_ext;
  end

  // ---------------- line store clearing pass ----------------
  logic             clr_active_r;
  logic [COL_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) clr_active_r <= 1'b0;
    end
  end

  // ---------------- acceptance and raster counters ----------------
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_xact;
  logic [LVL_W-1:0] fifo_level;
  logic [LVL_W+1:0] room_need;
  lcas_pkg::cell_flags_t flags_nxt;

  logic                  s1_valid_r;
  logic [COL_W-1:0]      s1_col_r;
  lcas_pkg::cell_flags_t s1_flags_r;

  // queue must hold what is in flight plus two results of a new cell
  assign room_need = (LVL_W+2)'(fifo_level) + (s1_valid_r ? (LVL_W+2)'(2) : '0)
                   + (LVL_W+2)'(2);
  assign in_ready  = !clr_active_r && (room_need <= (LVL_W+2)'(DEPTH));
  assign in_xact   = in_valid && in_ready;

  always_comb begin
    flags_nxt.padding  = CMP_W'(row_r) >= eff_h;
    flags_nxt.last_col = CMP_W'(col_r) >= (eff_w - CMP_W'(1));
    flags_nxt.bot      = in_cell_alive && !flags_nxt.padding;
    flags_nxt.col_zero = (col_r == '0);
    flags_nxt.row_ge1  = (row_r != '0);
    flags_nxt.row_ge2  = (row_r > ROW_W'(1));
    col_nxt = flags_nxt.last_col ? '0 : col_r + COL_W'(1);
    if (flags_nxt.last_col) row_nxt = flags_nxt.padding ? '0 : row_r + ROW_W'(1);
    else                    row_nxt = row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xact;
      if (in_xact) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xact) begin
      s1_col_r   <= col_r;
      s1_flags_r <= flags_nxt;
    end
  end

  // ---------------- line store ----------------
  lcas_pkg::line_pair_t ls_rd, ls_wr;
  logic                 ls_wr_en;
  logic [COL_W-1:0]     ls_wr_addr;
  lcas_pkg::win_col_t   new_col;

  // read at the column being accepted; data is there for the window stage
  always_comb begin
    new_col[0] = s1_flags_r.row_ge2 ? ls_rd.upper : 1'b0;
    new_col[1] = ls_rd.middle;
    new_col[2] = s1_flags_r.bot;
    if (clr_active_r) begin
      ls_wr_en     = 1'b1;
      ls_wr_addr   = clr_addr_r;
      ls_wr.upper  = 1'b0;
      ls_wr.middle = 1'b0;
    end else begin
      ls_wr_en     = s1_valid_r;
      ls_wr_addr   = s1_col_r;
      ls_wr.upper  = ls_rd.middle;
      ls_wr.middle = s1_flags_r.bot;
    end
  end

  lcas_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_addr (col_r),
    .rd_data (ls_rd),
    .wr_en   (ls_wr_en),
    .wr_addr (ls_wr_addr),
    .wr_data (ls_wr)
  );

  // ---------------- window chain: newest column enters cell 2 ----------------
  lcas_pkg::win_col_t c0_q, c1_q, c2_q, c0_n, c1_n, c2_n;
  logic               restart;

  assign restart = s1_flags_r.col_zero;

  lcas_win_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_valid_r), .clear(restart),
    .col_in(c1_q), .col_q(c0_q), .col_nxt(c0_n)
  );
  lcas_win_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_valid_r), .clear(restart),
    .col_in(c2_q), .col_q(c1_q), .col_nxt(c1_n)
  );
  lcas_win_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_valid_r), .clear(1'b0),
    .col_in(new_col), .col_q(c2_q), .col_nxt(c2_n)
  );

  // ---------------- results ----------------
  logic              res0_en, res1_en;
  lcas_pkg::result_t res0, res1, push_a_data;
  logic              push_a, push_b;

  always_comb begin
    // the cell one column back
    res0_en         = s1_valid_r && s1_flags_r.row_ge1 && !s1_flags_r.col_zero;
    res0.next_alive = lcas_pkg::life_next({c2_n, c1_n, c0_n});
    res0.row_end    = 1'b0;
    res0.frame_end  = 1'b0;
    // last column of the row: window shifted once more with an empty column
    res1_en         = s1_valid_r && s1_flags_r.row_ge1 && s1_flags_r.last_col;
    res1.next_alive = lcas_pkg::life_next({3'b000, c2_n, c1_n});
    res1.row_end    = 1'b1;
    res1.frame_end  = s1_flags_r.padding;
    // compact into queue slots
    push_a      = res0_en || res1_en;
    push_b      = res0_en && res1_en;
    push_a_data = res0_en ? res0 : res1;
  end

  lcas_pkg::result_t head;

  lcas_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (push_a),
    .data_a    (push_a_data),
    .push_b    (push_b),
    .data_b    (res1),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (head),
    .level     (fifo_level)
  );

  assign out_next_alive = head.next_alive;
  assign out_row_end    = head.row_end;
  assign out_frame_end  = head.frame_end;

  // ---------------- checks ----------------
  `LCAS_ASSERT_SAME(a_no_cell_during_clear, clk, rst_n, clr_active_r, !in_ready, "cell accepted during line store clear")
  `LCAS_ASSERT_NEXT(a_xact_reaches_window, clk, rst_n, in_valid && in_ready, s1_valid_r, "accepted cell missing from window stage")
  `LCAS_ASSERT_SAME(a_last_col_wraps, clk, rst_n, s1_valid_r && s1_flags_r.last_col, col_r == '0, "column counter did not wrap after last column")
  `LCAS_ASSERT_SAME(a_queue_bound, clk, rst_n, push_a, (LVL_W+1)'(fifo_level) + (push_b ? (LVL_W+1)'(2) : (LVL_W+1)'(1)) <= (LVL_W+1)'(DEPTH), "result queue overflow")
  `LCAS_ASSERT_NEXT(a_window_restart, clk, rst_n, s1_valid_r && restart, (c0_q == '0) && (c1_q == '0), "window not emptied at row start")

endmodule

@@ tb/life_next_gen_checker.sv @@
// Next-generation predictor and result checker for the Life step unit.
// Depends on lcas_pkg; watches the DUT ports only, never drives them.
module life_next_gen_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_cell_alive,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_next_alive,
  input  logic                           out_row_end,
  input  logic                           out_frame_end,
  input  logic                           cfg_wr_en,
  input  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcas_pkg::CFG_W-1:0]     cfg_wr_data,
  output int                             fail_count,
  output int                             pending_results
);

  localparam int MAX_W = lcas_pkg::MAX_WIDTH_DEF;
  localparam int MAX_H = lcas_pkg::MAX_HEIGHT_DEF;

  logic [lcas_pkg::CFG_W-1:0] width_reg;
  logic [lcas_pkg::CFG_W-1:0] height_reg;
  logic                       upper_line [MAX_W];
  logic                       middle_line [MAX_W];
  logic [8:0]                 window;
  int                         col_cnt;
  int                         row_cnt;
  lcas_pkg::result_t          next_gen_q [$];
  lcas_pkg::result_t          head;

  // window bit (col*3 + row), centre at bit 4
  function automatic logic life_rule_next(input logic [8:0] win);
    int live;
    live = 0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) live += win[k];
    end
    return (live == 3) || ((live == 2) && win[4]);
  endfunction

  // one accepted cell: advance the line stores and window, queue what it emits
  task automatic step_life_cell(input logic alive);
    int                w;
    int                h;
    int                c;
    int                r;
    logic              padding;
    logic              last_col;
    logic              top;
    logic              mid;
    logic              bot;
    lcas_pkg::result_t res;
    w = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : int'(width_reg);
    h = (height_reg < 1) ? 1 : (height_reg > MAX_H) ? MAX_H : int'(height_reg);
    c = col_cnt;
    r = row_cnt;
    padding  = (r >= h);
    last_col = (c >= w - 1);
    top = 1'b0;
    mid = 1'b0;
    bot = 1'b0;
    if (c < MAX_W) begin
      if (r >= 2) top = upper_line[c];
      mid = middle_line[c];
    end
    if (!padding) bot = alive;
    if (c == 0) window = {bot, mid, top, 6'b0};
    else window = {bot, mid, top, window[8:3]};
    if (c < MAX_W) begin
      upper_line[c]  = mid;
      middle_line[c] = bot;
    end
    if (r >= 1 && c >= 1) begin
      res.next_alive = life_rule_next(window);
      res.row_end    = 1'b0;
      res.frame_end  = 1'b0;
      next_gen_q.push_back(res);
    end
    if (last_col) begin
      // last column: shift in an empty column and emit the row's final cell
      if (r >= 1) begin
        window = {3'b000, window[8:3]};
        res.next_alive = life_rule_next(window);
        res.row_end    = 1'b1;
        res.frame_end  = padding;
        next_gen_q.push_back(res);
      end
      col_cnt = 0;
      row_cnt = padding ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = 10'(lcas_pkg::GRID_WIDTH_RST);
      height_reg = 10'(lcas_pkg::GRID_HEIGHT_RST);
      for (int i = 0; i < MAX_W; i++) begin
        upper_line[i]  = 1'b0;
        middle_line[i] = 1'b0;
      end
      window  = '0;
      col_cnt = 0;
      row_cnt = 0;
      next_gen_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == lcas_pkg::REG_GRID_WIDTH) width_reg = cfg_wr_data;
        else if (cfg_index == lcas_pkg::REG_GRID_HEIGHT) height_reg = cfg_wr_data;
      end
      // a result never leaves in the cycle its cell is accepted, so compare before predicting
      if (out_valid && out_ready) begin
        if (next_gen_q.size() == 0) begin
          $error("unexpected result transaction: next_alive %0b row_end %0b frame_end %0b",
                 out_next_alive, out_row_end, out_frame_end);
          fail_count = fail_count + 1;
        end else begin
          head = next_gen_q.pop_front();
          if (out_next_alive !== head.next_alive) begin
            $error("next_alive: expected %0b, actual %0b", head.next_alive, out_next_alive);
            fail_count = fail_count + 1;
          end
          if (out_row_end !== head.row_end) begin
            $error("row_end: expected %0b, actual %0b", head.row_end, out_row_end);
            fail_count = fail_count + 1;
          end
          if (out_frame_end !== head.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", head.frame_end, out_frame_end);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) step_life_cell(in_cell_alive);
    end
    pending_results = next_gen_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the Life step unit testbench: clock, reset, frame stimulus, verdict.
// Depends on lcas_pkg, life_cell_automaton_step_unit and life_next_gen_checker.
module testbench;

  // longest legal stretch without a transaction is the line store clearing pass
  // after reset, with the idle time around it; allow several times that
  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_cell_alive = 1'b0;
  logic                           out_ready = 1'b0;
  logic                           cfg_wr_en = 1'b0;
  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index = lcas_pkg::REG_GRID_WIDTH;
  logic [lcas_pkg::CFG_W-1:0]     cfg_wr_data = '0;

  logic in_ready;
  logic out_valid;
  logic out_next_alive;
  logic out_row_end;
  logic out_frame_end;

  int fail_count;
  int pending_results;

  int cells_sent = 0;
  int idle_cycles = 0;
  int rx_stall = 0;
  bit rx_burst = 1'b0;
  bit tx_burst = 1'b0;
  bit out_fire = 1'b0;

  always #5 clk = ~clk;

  life_cell_automaton_step_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cell_alive  (in_cell_alive),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_alive (out_next_alive),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data)
  );

  life_next_gen_checker i_next_gen_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_alive   (in_cell_alive),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_next_alive  (out_next_alive),
    .out_row_end     (out_row_end),
    .out_frame_end   (out_frame_end),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side: after each transaction draw a random stall with ready low.
  // Now and then switch into or out of a no-stall stretch.
  always @(posedge clk) begin
    out_fire <= out_valid && out_ready;
  end

  always @(negedge clk) begin
    if (out_fire) begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      rx_stall = rx_burst ? 0 : $urandom_range(0, 4);
    end
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write, entered and left at a falling edge. The enable is high for a
  // single cycle and the task then waits with it low, so back-to-back writes never put
  // two assignments on cfg_wr_en in one step.
  task automatic write_reg(input lcas_pkg::cfg_reg_e idx,
                           input logic [lcas_pkg::CFG_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // One cell transaction. Entered at a falling edge with valid possibly still
  // high from the previous cell; valid is dropped only when a gap is drawn,
  // otherwise the new payload follows directly.
  task automatic send_cell(input logic alive);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_alive <= alive;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
    cells_sent = cells_sent + 1;
  endtask

  // One frame: wait until the unit is idle, set the grid size, then stream
  // the grid plus its padding row. A negative density takes cells from the
  // pattern (bit r*width + c); the padding row is always random, as the unit
  // must ignore it.
  task automatic run_frame(input logic [lcas_pkg::CFG_W-1:0] width_val,
                           input logic [lcas_pkg::CFG_W-1:0] height_val,
                           input int density, input logic [63:0] pattern);
    int   w;
    int   h;
    int   r;
    int   c;
    logic alive;
    while (pending_results != 0) @(negedge clk);
    // the padding row's first cell emits nothing, so give the pipe time to settle
    repeat (4) @(negedge clk);
    write_reg(lcas_pkg::REG_GRID_WIDTH, width_val);
    write_reg(lcas_pkg::REG_GRID_HEIGHT, height_val);
    w = (width_val < 2) ? 2 :
        (width_val > lcas_pkg::MAX_WIDTH_DEF) ? lcas_pkg::MAX_WIDTH_DEF : int'(width_val);
    h = (height_val < 1) ? 1 :
        (height_val > lcas_pkg::MAX_HEIGHT_DEF) ? lcas_pkg::MAX_HEIGHT_DEF : int'(height_val);
    for (r = 0; r <= h; r++) begin
      for (c = 0; c < w; c++) begin
        if (r == h) alive = $urandom_range(0, 1);
        else if (density < 0) alive = pattern[r * w + c];
        else alive = ($urandom_range(0, 7) < density);
        send_cell(alive);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int frame_no;
    int sel;
    logic [lcas_pkg::CFG_W-1:0] w_val;
    logic [lcas_pkg::CFG_W-1:0] h_val;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames.
    // Vertical blinker in a 3x3 grid: the next generation is the horizontal one.
    run_frame(10'd3, 10'd3, -1, 64'b010_010_010);
    // Width below 2 acts as 2, height 0 acts as 1: one row of two live cells dies.
    run_frame(10'd1, 10'd0, -1, '1);
    // 2x2 block is a still life: every cell survives with three neighbours.
    run_frame(10'd2, 10'd2, -1, '1);

    // Random frames, mostly small. Two frames hit the size extremes with every
    // register bit set and clear: widest row (1023 clamps to MAX_WIDTH) on a
    // single row, and the tallest grid (1023 clamps to MAX_HEIGHT) at width 0.
    frame_no = 0;
    while (frame_no < 6 || cells_sent < 1800) begin
      if (frame_no == 2) begin
        run_frame(10'd1023, 10'd0, $urandom_range(1, 7), '0);
      end else if (frame_no == 5) begin
        run_frame(10'd0, 10'd1023, $urandom_range(1, 7), '0);
      end else begin
        sel = $urandom_range(0, 9);
        w_val = (sel == 0) ? 10'($urandom_range(0, 1)) : 10'($urandom_range(2, 20));
        sel = $urandom_range(0, 9);
        h_val = (sel == 0) ? 10'd0 : 10'($urandom_range(1, 8));
        run_frame(w_val, h_val, $urandom_range(1, 7), '0);
      end
      frame_no = frame_no + 1;
    end

    // drain; the watchdog covers a unit that never delivers
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ life_cell_automaton_step_unit.f @@
+incdir+src
src/lcas_pkg.sv
src/lcas_win_cell.sv
src/lcas_line_store.sv
src/lcas_out_fifo.sv
src/life_cell_automaton_step_unit.sv
tb/life_next_gen_checker.sv
tb/testbench.sv
